>>> rtl/pfsc_pkg.sv
`default_nettype none

package pfsc_pkg;

  localparam int SEP_W     = 32;
  localparam int OUT_W     = 48;
  localparam int CSQ_W     = 32;
  localparam int CFG_W     = 48;
  localparam int R2_W      = 41;
  localparam int RINV_W    = 63;
  localparam int RATIO_W   = 32;
  localparam int DIV_STEPS = 63;
  localparam int LAST_P    = 14;

  typedef enum logic [1:0] {
    CFG_CUTOFF_SQUARED = 2'd0,
    CFG_SPLINE_OFFSET  = 2'd1,
    CFG_SPLINE_SLOPE   = 2'd2
  } cfg_idx_t;

  localparam logic [CSQ_W-1:0]        CSQ_RST   = 32'd104857600;
  localparam logic signed [OUT_W-1:0] OFF_RST   = 48'sd273753;
  localparam logic signed [OUT_W-1:0] SLOPE_RST = -48'sd817867;

  localparam logic [OUT_W-1:0] SAT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [52:0]      ONE_Q38  = 53'd1 << 38;
  localparam logic [R2_W-1:0]  SHORT_R2 = 41'd1 << 20;

  typedef logic [3:0][SEP_W-1:0] sep_vec_t;

  // per-item context that rides along the arithmetic stages
  typedef struct packed {
    sep_vec_t          sep;
    logic              in_cut;
    logic              is_zero;
    logic              is_short;
    logic [RINV_W-1:0] rinv2;
    logic [48:0]       s1;
    logic [49:0]       s2;
    logic [OUT_W-1:0]  pot;
    logic [OUT_W-1:0]  vir;
  } ctx_t;

  // one stage of the two restoring dividers
  typedef struct packed {
    sep_vec_t           sep;
    logic               in_cut;
    logic               is_zero;
    logic               is_short;
    logic [31:0]        dvsr;
    logic [31:0]        rem_a;
    logic [RINV_W-1:0]  q_a;
    logic [31:0]        rem_b;
    logic [RATIO_W-1:0] q_b;
  } dstage_t;

  typedef struct packed {
    logic [3:0][OUT_W-1:0] frc;
    logic [OUT_W-1:0]      pot;
    logic [OUT_W-1:0]      vir;
    logic                  in_cut;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/pair_force_spline_cutoff.sv
// Lennard-Jones pair force with a quadratic-spline shifted cutoff.
// Input channel: in_valid / in_stall with one separation vector (sep_x..sep_w,
// signed Q8.24) per transaction. Output channel: out_valid / out_stall with
// force_x..force_w, potential and virial (signed Q24.24, saturating) and
// within_cutoff. Configuration: cfg_we / cfg_index / cfg_wdata writes
// cutoff_squared (0), spline_offset (1) and spline_slope (2); other indexes
// are ignored. Write configuration only while the pipeline is empty.
// Throughput: one transaction per cycle while in_stall is low. The depth is
// set by the bit-per-stage divider that forms 2^62 / r2 (63 stages) plus the
// split multiplies for r^-6 and the force.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// cutoff 2.5^2 and spline terms. When the receiver stalls, the output register
// holds and one more result lands in a skid register; then in_stall rises and
// the whole pipeline holds until the skid register drains.
`default_nettype none

module pair_force_spline_cutoff (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [pfsc_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [pfsc_pkg::SEP_W-1:0]   in_sep_x,
  input  wire logic signed [pfsc_pkg::SEP_W-1:0]   in_sep_y,
  input  wire logic signed [pfsc_pkg::SEP_W-1:0]   in_sep_z,
  input  wire logic signed [pfsc_pkg::SEP_W-1:0]   in_sep_w,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [pfsc_pkg::OUT_W-1:0]        out_force_x,
  output logic signed [pfsc_pkg::OUT_W-1:0]        out_force_y,
  output logic signed [pfsc_pkg::OUT_W-1:0]        out_force_z,
  output logic signed [pfsc_pkg::OUT_W-1:0]        out_force_w,
  output logic signed [pfsc_pkg::OUT_W-1:0]        out_potential,
  output logic signed [pfsc_pkg::OUT_W-1:0]        out_virial,
  output logic                                     out_within_cutoff
);

  localparam int NP = pfsc_pkg::LAST_P;
  localparam int ND = pfsc_pkg::DIV_STEPS;

  // configuration
  logic [pfsc_pkg::CSQ_W-1:0]        csq_r;
  logic signed [pfsc_pkg::OUT_W-1:0] off_r;
  logic signed [pfsc_pkg::OUT_W-1:0] slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csq_r   <= pfsc_pkg::CSQ_RST;
      off_r   <= pfsc_pkg::OFF_RST;
      slope_r <= pfsc_pkg::SLOPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfsc_pkg::CFG_CUTOFF_SQUARED: csq_r   <= cfg_wdata[pfsc_pkg::CSQ_W-1:0];
        pfsc_pkg::CFG_SPLINE_OFFSET:  off_r   <= cfg_wdata;
        pfsc_pkg::CFG_SPLINE_SLOPE:   slope_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // flow control
  logic adv;
  logic deliver;
  logic out_v_r;
  logic skid_v_r;
  pfsc_pkg::res_t out_r;
  pfsc_pkg::res_t skid_r;
  pfsc_pkg::res_t res;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // valid bits
  logic             s0_v_r, s1_v_r, s2_v_r;
  logic [ND:0]      dv_v_r;
  logic [NP:1]      pv_r;

  assign deliver = pv_r[NP] && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      dv_v_r <= '0;
      pv_r   <= '0;
    end else if (adv) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      dv_v_r <= {dv_v_r[ND-1:0], s2_v_r};
      pv_r   <= {pv_r[NP-1:1], dv_v_r[ND]};
    end
  end

  // squares and r2
  pfsc_pkg::sep_vec_t              s0_sep_r, s1_sep_r, s2_sep_r;
  logic [3:0][63:0]                s1_sq_r;
  logic [pfsc_pkg::R2_W-1:0]       s2_r2_r;
  logic [3:0][31:0]                s0_mag;
  logic [65:0]                     sq_sum;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s0_mag[i] = s0_sep_r[i][31] ? 32'd0 - s0_sep_r[i] : s0_sep_r[i];
    end
    sq_sum = 66'(s1_sq_r[0]) + 66'(s1_sq_r[1]) + 66'(s1_sq_r[2]) + 66'(s1_sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sep_r <= {in_sep_w, in_sep_z, in_sep_y, in_sep_x};
      for (int i = 0; i < 4; i++) begin
        s1_sq_r[i] <= 64'(s0_mag[i]) * 64'(s0_mag[i]);
      end
      s1_sep_r <= s0_sep_r;
      s2_r2_r  <= sq_sum[64:24];
      s2_sep_r <= s1_sep_r;
    end
  end

  // dividers: 2^62 / r2 and (r2 << 32) / cutoff_squared, one quotient bit a stage
  function automatic pfsc_pkg::dstage_t dv_step(pfsc_pkg::dstage_t d, int j,
                                                logic [31:0] csq);
    pfsc_pkg::dstage_t o;
    logic [32:0]       ta;
    logic [32:0]       tb;
    logic              ga;
    logic              gb;
    o  = d;
    ta = {d.rem_a, 1'(j == 0)};
    ga = ta >= {1'b0, d.dvsr};
    o.rem_a = ga ? 32'(ta - {1'b0, d.dvsr}) : ta[31:0];
    o.q_a   = {d.q_a[pfsc_pkg::RINV_W-2:0], ga};
    if (j < pfsc_pkg::RATIO_W) begin
      tb = {d.rem_b, 1'b0};
      gb = tb >= {1'b0, csq};
      o.rem_b = gb ? 32'(tb - {1'b0, csq}) : tb[31:0];
      o.q_b   = {d.q_b[pfsc_pkg::RATIO_W-2:0], gb};
    end
    return o;
  endfunction

  pfsc_pkg::dstage_t dv_r [0:ND];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].sep      <= s2_sep_r;
      dv_r[0].in_cut   <= s2_r2_r < pfsc_pkg::R2_W'(csq_r);
      dv_r[0].is_zero  <= s2_r2_r == '0;
      dv_r[0].is_short <= s2_r2_r <= pfsc_pkg::SHORT_R2;
      dv_r[0].dvsr     <= s2_r2_r[31:0];
      dv_r[0].rem_a    <= '0;
      dv_r[0].q_a      <= '0;
      dv_r[0].rem_b    <= s2_r2_r[31:0];
      dv_r[0].q_b      <= '0;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j+1] <= dv_step(dv_r[j], j, csq_r);
      end
    end
  end

  // arithmetic stages
  pfsc_pkg::ctx_t ctx_r [1:NP];
  pfsc_pkg::ctx_t ctx2_nxt, ctx9_nxt;

  logic [63:0] p1_rr_ll_r;
  logic [41:0] p1_rr_lh_r;
  logic [19:0] p1_rr_hh_r;
  logic [63:0] p1_sd_l_r, p1_sr_l_r;
  logic [47:0] p1_sd_h_r, p1_sr_h_r;
  logic [47:0] p1_sm_r;
  logic        p1_dz_r, p1_sneg_r;
  logic [45:0] p2_r4_r;
  logic [63:0] p3_u_ll_r;
  logic [41:0] p3_u_lh_r;
  logic [45:0] p3_u_hl_r;
  logic [23:0] p3_u_hh_r;
  logic [49:0] p4_u_r;
  logic [49:0] p5_u_r;
  logic [50:0] p5_mp_r;
  logic [51:0] p5_mv_r;
  logic        p5_pneg_r, p5_vneg_r;
  logic [63:0] p6_pp_ll_r, p6_vp_ll_r;
  logic [50:0] p6_pp_lh_r;
  logic [51:0] p6_vp_lh_r;
  logic [49:0] p6_pp_hl_r, p6_vp_hl_r;
  logic [36:0] p6_pp_hh_r;
  logic [37:0] p6_vp_hh_r;
  logic        p6_pneg_r, p6_vneg_r;
  logic [48:0] p7_lp_r;
  logic [49:0] p7_lv_r;
  logic        p7_pneg_r, p7_vneg_r;
  logic signed [57:0] p8_pot_r, p8_vir_r;
  logic [47:0]        p10_vmag_r;
  logic [3:0][31:0]   p10_smag_r;
  logic [3:0]         p10_fneg_r, p11_fneg_r, p12_fneg_r, p13_fneg_r, p14_fneg_r;
  logic [3:0][63:0]   p11_fvl_r;
  logic [3:0][47:0]   p11_fvh_r;
  logic [3:0][54:0]   p12_f_r;
  logic [3:0][63:0]   p13_ll_r;
  logic [3:0][62:0]   p13_lh_r;
  logic [3:0][54:0]   p13_hl_r;
  logic [3:0][53:0]   p13_hh_r;
  logic [3:0]         p14_big_r;
  logic [3:0][46:0]   p14_m_r;

  // combinational values per stage
  logic [41:0]  ri1;
  logic [31:0]  ratio1, dl1;
  logic [47:0]  sm1;
  logic [83:0]  rr2;
  logic [79:0]  sd2, sr2;
  logic [47:0]  s1mag2;
  logic [48:0]  s2mag2;
  logic [41:0]  ri3;
  logic [88:0]  up4;
  logic [52:0]  um5, vm5;
  logic [103:0] ps7, vs7;
  logic signed [57:0] lps8, lvs8, ljp8, ljv8;
  logic [47:0]  pot9, vir9;
  logic [3:0][79:0]  fs12;
  logic [62:0]  rinv13;
  logic [3:0][117:0] qs14;

  function automatic logic [47:0] sat48(logic signed [57:0] x);
    logic [47:0] y;
    if (!x[57] && (x[56:47] != '0)) begin
      y = pfsc_pkg::SAT_MAX;
    end else if (x[57] && (x[56:47] != '1)) begin
      y = pfsc_pkg::SAT_MIN;
    end else begin
      y = x[47:0];
    end
    return y;
  endfunction

  always_comb begin
    ri1    = dv_r[ND].q_a[41:0];
    ratio1 = dv_r[ND].q_b;
    dl1    = 32'd0 - ratio1;
    sm1    = slope_r[47] ? 48'd0 - slope_r : slope_r;

    rr2 = 84'(p1_rr_ll_r) + (84'(p1_rr_lh_r) << 33) + (84'(p1_rr_hh_r) << 64);
    sd2 = 80'(p1_sd_l_r) + (80'(p1_sd_h_r) << 32);
    sr2 = 80'(p1_sr_l_r) + (80'(p1_sr_h_r) << 32);
    s1mag2 = p1_dz_r ? p1_sm_r : sd2[79:32];
    s2mag2 = sr2[79:31];

    ctx2_nxt    = ctx_r[1];
    ctx2_nxt.s1 = p1_sneg_r ? {1'b0, s1mag2} : 49'd0 - {1'b0, s1mag2};
    ctx2_nxt.s2 = p1_sneg_r ? 50'd0 - {1'b0, s2mag2} : {1'b0, s2mag2};

    ri3 = ctx_r[2].rinv2[41:0];
    up4 = 89'(p3_u_ll_r) + (89'(p3_u_lh_r) << 32) + (89'(p3_u_hl_r) << 32)
        + (89'(p3_u_hh_r) << 64);

    um5 = 53'(p4_u_r) - pfsc_pkg::ONE_Q38;
    vm5 = 53'({p4_u_r, 1'b0}) - pfsc_pkg::ONE_Q38;

    ps7 = 104'(p6_pp_ll_r) + (104'(p6_pp_lh_r) << 32) + (104'(p6_pp_hl_r) << 32)
        + (104'(p6_pp_hh_r) << 64);
    vs7 = 104'(p6_vp_ll_r) + (104'(p6_vp_lh_r) << 32) + (104'(p6_vp_hl_r) << 32)
        + (104'(p6_vp_hh_r) << 64);

    lps8 = p7_pneg_r ? -$signed(58'(p7_lp_r)) : $signed(58'(p7_lp_r));
    lvs8 = p7_vneg_r ? -$signed(58'(p7_lv_r)) : $signed(58'(p7_lv_r));
    ljp8 = lps8 <<< 2;
    ljv8 = (lvs8 <<< 4) + (lvs8 <<< 3);

    pot9 = ctx_r[8].is_short ? pfsc_pkg::SAT_MAX : sat48(p8_pot_r);
    vir9 = ctx_r[8].is_short ? pfsc_pkg::SAT_MAX : sat48(p8_vir_r);

    ctx9_nxt     = ctx_r[8];
    ctx9_nxt.pot = pot9;
    ctx9_nxt.vir = vir9;

    rinv13 = ctx_r[12].rinv2;
    for (int i = 0; i < 4; i++) begin
      fs12[i] = 80'(p11_fvl_r[i]) + (80'(p11_fvh_r[i]) << 32);
      qs14[i] = 118'(p13_ll_r[i]) + (118'(p13_lh_r[i]) << 32)
              + (118'(p13_hl_r[i]) << 32) + (118'(p13_hh_r[i]) << 64);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // context shift; stage 2 adds the spline terms, stage 9 the saturated sums
      ctx_r[1].sep      <= dv_r[ND].sep;
      ctx_r[1].in_cut   <= dv_r[ND].in_cut;
      ctx_r[1].is_zero  <= dv_r[ND].is_zero;
      ctx_r[1].is_short <= dv_r[ND].is_short;
      ctx_r[1].rinv2    <= dv_r[ND].q_a;
      ctx_r[1].s1       <= '0;
      ctx_r[1].s2       <= '0;
      ctx_r[1].pot      <= '0;
      ctx_r[1].vir      <= '0;
      for (int k = 2; k <= NP; k++) begin
        if (k == 2) begin
          ctx_r[k] <= ctx2_nxt;
        end else if (k == 9) begin
          ctx_r[k] <= ctx9_nxt;
        end else begin
          ctx_r[k] <= ctx_r[k-1];
        end
      end

      // P1: r^-2 squared and spline partial products
      p1_rr_ll_r <= 64'(ri1[31:0]) * 64'(ri1[31:0]);
      p1_rr_lh_r <= 42'(ri1[31:0]) * 42'(ri1[41:32]);
      p1_rr_hh_r <= 20'(ri1[41:32]) * 20'(ri1[41:32]);
      p1_sd_l_r  <= 64'(sm1[31:0]) * 64'(dl1);
      p1_sd_h_r  <= 48'(sm1[47:32]) * 48'(dl1);
      p1_sr_l_r  <= 64'(sm1[31:0]) * 64'(ratio1);
      p1_sr_h_r  <= 48'(sm1[47:32]) * 48'(ratio1);
      p1_sm_r    <= sm1;
      p1_dz_r    <= ratio1 == '0;
      p1_sneg_r  <= slope_r[47];

      // P2: r^-4
      p2_r4_r  <= rr2[83:38];

      // P3/P4: r^-6
      p3_u_ll_r <= 64'(p2_r4_r[31:0]) * 64'(ri3[31:0]);
      p3_u_lh_r <= 42'(p2_r4_r[31:0]) * 42'(ri3[41:32]);
      p3_u_hl_r <= 46'(p2_r4_r[45:32]) * 46'(ri3[31:0]);
      p3_u_hh_r <= 24'(p2_r4_r[45:32]) * 24'(ri3[41:32]);
      p4_u_r    <= up4[87:38];

      // P5: u - 1 and 2u - 1 as sign and magnitude
      p5_u_r    <= p4_u_r;
      p5_pneg_r <= um5[52];
      p5_vneg_r <= vm5[52];
      p5_mp_r   <= um5[52] ? 51'(53'd0 - um5) : um5[50:0];
      p5_mv_r   <= vm5[52] ? 52'(53'd0 - vm5) : vm5[51:0];

      // P6/P7: u(u-1) and u(2u-1)
      p6_pp_ll_r <= 64'(p5_u_r[31:0]) * 64'(p5_mp_r[31:0]);
      p6_pp_lh_r <= 51'(p5_u_r[31:0]) * 51'(p5_mp_r[50:32]);
      p6_pp_hl_r <= 50'(p5_u_r[49:32]) * 50'(p5_mp_r[31:0]);
      p6_pp_hh_r <= 37'(p5_u_r[49:32]) * 37'(p5_mp_r[50:32]);
      p6_vp_ll_r <= 64'(p5_u_r[31:0]) * 64'(p5_mv_r[31:0]);
      p6_vp_lh_r <= 52'(p5_u_r[31:0]) * 52'(p5_mv_r[51:32]);
      p6_vp_hl_r <= 50'(p5_u_r[49:32]) * 50'(p5_mv_r[31:0]);
      p6_vp_hh_r <= 38'(p5_u_r[49:32]) * 38'(p5_mv_r[51:32]);
      p6_pneg_r  <= p5_pneg_r;
      p6_vneg_r  <= p5_vneg_r;
      p7_lp_r    <= ps7[100:52];
      p7_lv_r    <= vs7[101:52];
      p7_pneg_r  <= p6_pneg_r;
      p7_vneg_r  <= p6_vneg_r;

      // P8: add the spline terms
      p8_pot_r <= ljp8 + 58'(off_r) + 58'($signed(ctx_r[7].s1));
      p8_vir_r <= ljv8 - 58'($signed(ctx_r[7].s2));

      // P10..P14: force = virial * sep >> 24, then * r^-2 >> 38
      p10_vmag_r <= ctx_r[9].vir[47] ? 48'd0 - ctx_r[9].vir : ctx_r[9].vir;
      for (int i = 0; i < 4; i++) begin
        p10_smag_r[i] <= ctx_r[9].sep[i][31] ? 32'd0 - ctx_r[9].sep[i] : ctx_r[9].sep[i];
        p10_fneg_r[i] <= ctx_r[9].vir[47] ^ ctx_r[9].sep[i][31];
        p11_fvl_r[i]  <= 64'(p10_vmag_r[31:0]) * 64'(p10_smag_r[i]);
        p11_fvh_r[i]  <= 48'(p10_vmag_r[47:32]) * 48'(p10_smag_r[i]);
        p12_f_r[i]    <= fs12[i][78:24];
        p13_ll_r[i]   <= 64'(p12_f_r[i][31:0]) * 64'(rinv13[31:0]);
        p13_lh_r[i]   <= 63'(p12_f_r[i][31:0]) * 63'(rinv13[62:32]);
        p13_hl_r[i]   <= 55'(p12_f_r[i][54:32]) * 55'(rinv13[31:0]);
        p13_hh_r[i]   <= 54'(p12_f_r[i][54:32]) * 54'(rinv13[62:32]);
        p14_big_r[i]  <= |qs14[i][117:85];
        p14_m_r[i]    <= qs14[i][84:38];
      end
      p11_fneg_r <= p10_fneg_r;
      p12_fneg_r <= p11_fneg_r;
      p13_fneg_r <= p12_fneg_r;
      p14_fneg_r <= p13_fneg_r;
    end
  end

  // result selection
  always_comb begin
    res = '0;
    if (ctx_r[NP].in_cut) begin
      res.in_cut = 1'b1;
      if (ctx_r[NP].is_zero) begin
        res.pot = pfsc_pkg::SAT_MAX;
        res.vir = pfsc_pkg::SAT_MAX;
        for (int i = 0; i < 4; i++) begin
          if (ctx_r[NP].sep[i][31]) begin
            res.frc[i] = pfsc_pkg::SAT_MIN;
          end else if (ctx_r[NP].sep[i] != '0) begin
            res.frc[i] = pfsc_pkg::SAT_MAX;
          end
        end
      end else begin
        res.pot = ctx_r[NP].pot;
        res.vir = ctx_r[NP].vir;
        for (int i = 0; i < 4; i++) begin
          if (p14_big_r[i]) begin
            res.frc[i] = p14_fneg_r[i] ? pfsc_pkg::SAT_MIN : pfsc_pkg::SAT_MAX;
          end else begin
            res.frc[i] = p14_fneg_r[i] ? 48'd0 - {1'b0, p14_m_r[i]} : {1'b0, p14_m_r[i]};
          end
        end
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= deliver;
      end
    end else if (deliver) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (deliver) begin
        out_r <= res;
      end
    end else if (deliver) begin
      skid_r <= res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_force_x       = out_r.frc[0];
  assign out_force_y       = out_r.frc[1];
  assign out_force_z       = out_r.frc[2];
  assign out_force_w       = out_r.frc[3];
  assign out_potential     = out_r.pot;
  assign out_virial        = out_r.vir;
  assign out_within_cutoff = out_r.in_cut;

endmodule

`default_nettype wire

>>> sim/pair_force_spline_cutoff_tb.sv
`timescale 1ns / 100ps

module pair_force_spline_cutoff_tb;

  localparam int  LATENCY   = 81;
  localparam int  N_RANDOM  = 550;
  localparam longint MAX_CYCLES = 400000;
  localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_8000_0000_0000;
  localparam logic [63:0] CAP62 = 64'd1 << 62;

  typedef struct packed {
    logic signed [pfsc_pkg::OUT_W-1:0] fx, fy, fz, fw, pot, vir;
    logic                              in_cut;
  } force_res_t;

  typedef struct {
    logic signed [pfsc_pkg::SEP_W-1:0] sep[4];
    bit                                has_exp;
    force_res_t                        exp_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [pfsc_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [pfsc_pkg::SEP_W-1:0] in_sep_x = '0, in_sep_y = '0;
  logic signed [pfsc_pkg::SEP_W-1:0] in_sep_z = '0, in_sep_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [pfsc_pkg::OUT_W-1:0] out_force_x, out_force_y, out_force_z, out_force_w;
  logic signed [pfsc_pkg::OUT_W-1:0] out_potential, out_virial;
  logic out_within_cutoff;

  pair_force_spline_cutoff i_dut (.*);

  always #2 clk = ~clk;

  // shadow copy of the configuration registers
  logic [pfsc_pkg::CSQ_W-1:0]        cur_cutoff_sq;
  logic signed [pfsc_pkg::OUT_W-1:0] cur_offset;
  logic signed [pfsc_pkg::OUT_W-1:0] cur_slope;

  force_res_t expected_forces[$];
  int  errors = 0;
  int  n_results = 0;
  int  n_inside = 0;
  longint cycles = 0;
  bit  stall_enable = 1'b0;

  // unsigned (a*b)>>s, capped at 2^62
  function automatic logic [63:0] umul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    if (p > {64'd0, CAP62}) return CAP62;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] smul_shr(logic signed [63:0] a,
                                                   logic signed [63:0] b, int s);
    logic [63:0] m;
    m = umul_shr(a < 0 ? -a : a, b < 0 ? -b : b, s);
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp48(logic signed [63:0] v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic force_res_t predict_force(logic signed [pfsc_pkg::SEP_W-1:0] sep[4]);
    force_res_t r;
    logic [63:0] hi_sum, lo_sum, r2, sq, m, rinv2, r4;
    logic signed [63:0] u, pot, vir, ratio, f;
    logic signed [63:0] fr[4];
    logic [95:0] num;
    hi_sum = 0;
    lo_sum = 0;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      m = sep[i] < 0 ? 64'(-64'(sep[i])) : 64'(sep[i]);
      sq = m * m;
      hi_sum += sq >> 24;
      lo_sum += sq & 64'hFF_FFFF;
    end
    r2 = hi_sum + (lo_sum >> 24);
    if (!(r2 < {32'd0, cur_cutoff_sq})) return r;
    r.in_cut = 1'b1;
    if (r2 == 0) begin
      for (int i = 0; i < 4; i++)
        fr[i] = sep[i] > 0 ? SAT_HI : (sep[i] < 0 ? SAT_LO : 64'sd0);
      pot = SAT_HI;
      vir = SAT_HI;
    end else begin
      rinv2 = CAP62 / r2;
      if (r2 <= 64'(pfsc_pkg::SHORT_R2)) begin
        pot = SAT_HI;
        vir = SAT_HI;
      end else begin
        r4 = umul_shr(rinv2, rinv2, 38);
        u = $signed(umul_shr(r4, rinv2, 38));
        num = {32'd0, r2} << 32;
        ratio = $signed(64'(num / cur_cutoff_sq));
        pot = 4 * smul_shr(u, u - (64'sd1 <<< 38), 52) + 64'(cur_offset)
              + smul_shr(64'(cur_slope), ratio - (64'sd1 <<< 32), 32);
        vir = 24 * smul_shr(u, 2 * u - (64'sd1 <<< 38), 52)
              - smul_shr(64'(cur_slope), ratio, 31);
        pot = clamp48(pot);
        vir = clamp48(vir);
      end
      for (int i = 0; i < 4; i++) begin
        f = smul_shr(vir, 64'(sep[i]), 24);
        fr[i] = clamp48(smul_shr(f, $signed(rinv2), 38));
      end
    end
    r.fx = fr[0][pfsc_pkg::OUT_W-1:0];
    r.fy = fr[1][pfsc_pkg::OUT_W-1:0];
    r.fz = fr[2][pfsc_pkg::OUT_W-1:0];
    r.fw = fr[3][pfsc_pkg::OUT_W-1:0];
    r.pot = pot[pfsc_pkg::OUT_W-1:0];
    r.vir = vir[pfsc_pkg::OUT_W-1:0];
    return r;
  endfunction

  task automatic write_reg(pfsc_pkg::cfg_idx_t idx, logic [pfsc_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pfsc_pkg::CFG_CUTOFF_SQUARED: cur_cutoff_sq = val[pfsc_pkg::CSQ_W-1:0];
      pfsc_pkg::CFG_SPLINE_OFFSET:  cur_offset = val;
      pfsc_pkg::CFG_SPLINE_SLOPE:   cur_slope = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // drive one transaction; valid stays high if the next one follows directly
  task automatic send_sep(logic signed [pfsc_pkg::SEP_W-1:0] sep[4], force_res_t res);
    in_valid <= 1'b1;
    in_sep_x <= sep[0];
    in_sep_y <= sep[1];
    in_sep_z <= sep[2];
    in_sep_w <= sep[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_forces.push_back(res);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [pfsc_pkg::SEP_W-1:0] rand_comp(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
      2: return $signed(32'($urandom_range(0, 32'h0000_4000)) - 32'h0000_2000);
      default: return $signed(32'($urandom_range(0, 32'h0300_0000)) - 32'h0180_0000);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic signed [pfsc_pkg::SEP_W-1:0] s[4];
    int burst;
    int mode;
    int k;
    k = 0;
    while (k < n) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && k < n; b++) begin
        mode = $urandom_range(0, 9);
        mode = mode == 0 ? 0 : (mode == 1 ? 2 : (mode < 5 ? 1 : 3));
        for (int i = 0; i < 4; i++) s[i] = rand_comp(mode);
        if ($urandom_range(0, 3) != 0) s[3] = '0;
        send_sep(s, predict_force(s));
        k++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
    end
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern: stretches of random stalls, else free flow with periodic forced stalls
  always @(posedge clk) begin
    if (stall_enable && (cycles % 200) >= 120) out_stall <= ($urandom_range(0, 2) == 0);
    else if (stall_enable && (cycles % 37) < 3) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    force_res_t e;
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_forces.size() == 0) begin
        $error("result without a pending expectation");
        errors++;
      end else begin
        e = expected_forces.pop_front();
        if (out_force_x !== e.fx) begin
          $error("force_x expected %0d got %0d", e.fx, out_force_x); errors++;
        end
        if (out_force_y !== e.fy) begin
          $error("force_y expected %0d got %0d", e.fy, out_force_y); errors++;
        end
        if (out_force_z !== e.fz) begin
          $error("force_z expected %0d got %0d", e.fz, out_force_z); errors++;
        end
        if (out_force_w !== e.fw) begin
          $error("force_w expected %0d got %0d", e.fw, out_force_w); errors++;
        end
        if (out_potential !== e.pot) begin
          $error("potential expected %0d got %0d", e.pot, out_potential); errors++;
        end
        if (out_virial !== e.vir) begin
          $error("virial expected %0d got %0d", e.vir, out_virial); errors++;
        end
        if (out_within_cutoff !== e.in_cut) begin
          $error("within_cutoff expected %0b got %0b", e.in_cut, out_within_cutoff);
          errors++;
        end
        if (e.in_cut) n_inside++;
      end
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t mk_row(int x, int y, int z, int w, bit known,
                                       force_res_t res);
    stim_row_t r;
    r.sep[0] = x;
    r.sep[1] = y;
    r.sep[2] = z;
    r.sep[3] = w;
    r.has_exp = known;
    r.exp_res = res;
    return r;
  endfunction

  initial begin
    force_res_t zero_res, sat_res, any_res;
    logic signed [pfsc_pkg::SEP_W-1:0] s[4];
    zero_res = '0;
    any_res = '0;
    sat_res = '{fx: '0, fy: '0, fz: '0, fw: '0, pot: pfsc_pkg::SAT_MAX,
                vir: pfsc_pkg::SAT_MAX, in_cut: 1'b1};
    cur_cutoff_sq = pfsc_pkg::CSQ_RST;
    cur_offset = pfsc_pkg::OFF_RST;
    cur_slope = pfsc_pkg::SLOPE_RST;

    // zero distance, axis-aligned saturated forces, outside cutoff, extremes
    directed.push_back(mk_row(0, 0, 0, 0, 1, sat_res));
    sat_res.fx = pfsc_pkg::SAT_MAX; sat_res.fy = pfsc_pkg::SAT_MIN;
    directed.push_back(mk_row(1, -1, 0, 0, 1, sat_res));
    sat_res.fx = '0; sat_res.fy = '0;
    sat_res.fz = pfsc_pkg::SAT_MIN; sat_res.fw = pfsc_pkg::SAT_MAX;
    directed.push_back(mk_row(0, 0, -1, 1, 1, sat_res));
    directed.push_back(mk_row(32'h7FFF_FFFF, 0, 0, 0, 1, zero_res));
    directed.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 1, zero_res));
    directed.push_back(mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 1, zero_res));
    directed.push_back(mk_row(32'h0280_0000, 0, 0, 0, 1, zero_res));
    directed.push_back(mk_row(32'h027F_FFFF, 0, 0, 0, 0, any_res));
    directed.push_back(mk_row(32'h0040_0000, 0, 0, 0, 0, any_res));
    directed.push_back(mk_row(32'h0040_0001, 0, 0, 0, 0, any_res));
    directed.push_back(mk_row(32'h003F_FFFF, 0, 0, 0, 0, any_res));
    directed.push_back(mk_row(32'h0100_0000, 0, 0, 0, 0, any_res));
    directed.push_back(mk_row(32'h011F_5A00, 0, 0, 0, 0, any_res));
    directed.push_back(mk_row(0, 32'h0100_0000, -32'h0080_0000, 32'h0080_0000, 0, any_res));
    directed.push_back(mk_row(-32'h00C0_0000, -32'h00C0_0000, 32'h00C0_0000, 0, 0, any_res));
    directed.push_back(mk_row(32'h0000_1000, 32'h0000_0800, 0, 32'hFFFF_F000, 0, any_res));
    directed.push_back(mk_row(-32'h0180_0000, 32'h0100_0000, 0, -32'h0001_0000, 0, any_res));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      s = directed[k].sep;
      send_sep(s, directed[k].has_exp ? directed[k].exp_res : predict_force(s));
    end
    in_valid <= 1'b0;
    drain();

    stall_enable = 1'b1;
    random_phase(N_RANDOM / 4);
    drain();

    // wide cutoff, large spline terms; the ignored index must not disturb anything
    write_reg(pfsc_pkg::CFG_CUTOFF_SQUARED, 48'hFFFF_FFFF);
    write_reg(pfsc_pkg::CFG_SPLINE_OFFSET, 48'h7FFF_FFFF_FFFF);
    write_reg(pfsc_pkg::CFG_SPLINE_SLOPE, 48'h8000_0000_0000);
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_wdata <= 48'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
    random_phase(N_RANDOM / 4);
    drain();

    // zero cutoff: everything falls outside
    write_reg(pfsc_pkg::CFG_CUTOFF_SQUARED, '0);
    write_reg(pfsc_pkg::CFG_SPLINE_OFFSET, 48'h8000_0000_0000);
    write_reg(pfsc_pkg::CFG_SPLINE_SLOPE, 48'h7FFF_FFFF_FFFF);
    random_phase(30);
    drain();

    // random mid-range settings
    write_reg(pfsc_pkg::CFG_CUTOFF_SQUARED,
              {16'd0, 32'($urandom_range(32'h0100_0000, 32'h2000_0000))});
    write_reg(pfsc_pkg::CFG_SPLINE_OFFSET, 48'({$urandom(), $urandom()}));
    write_reg(pfsc_pkg::CFG_SPLINE_SLOPE, 48'({$urandom(), $urandom()}));
    random_phase(N_RANDOM / 4);
    drain();

    write_reg(pfsc_pkg::CFG_CUTOFF_SQUARED, 48'h0000_0001);
    random_phase(20);
    drain();

    write_reg(pfsc_pkg::CFG_CUTOFF_SQUARED, 48'(pfsc_pkg::CSQ_RST));
    write_reg(pfsc_pkg::CFG_SPLINE_OFFSET, pfsc_pkg::OFF_RST);
    write_reg(pfsc_pkg::CFG_SPLINE_SLOPE, pfsc_pkg::SLOPE_RST);
    random_phase(N_RANDOM / 4);
    drain();

    $display("Covered %0d results (%0d inside the cutoff) over six register settings,",
             n_results, n_inside);
    $display("with sender bursts and receiver stalls; %0d mismatches.", errors);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
